[sv/snpsq_pkg.sv]
// Shared types, widths and register codes of the SNP site qualifier.
package snpsq_pkg;

   localparam int IN_CNT_W   = 24;
   localparam int IN_DEP_W   = IN_CNT_W + 2;
   localparam int REF_W      = 3;
   localparam int SUM_W      = 34;
   localparam int FREQ_W     = 17;
   localparam int MIN_ALT_W  = 24;
   localparam int MIN_DEP_W  = 26;
   localparam int BASES      = 4;
   localparam int ALT_SLOTS  = 3;
   localparam int BASE_W     = 2;
   localparam int Q16_SHIFT  = 16;

   localparam int COUNT_BITS_DEFAULT  = 24;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 34;
   localparam logic [CSR_IDX_W-1:0] CSR_MAJOR_FREQ       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MINOR_FREQ       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POP_DEPTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POP_ALT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLE_ALT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLE_DEPTH = 3'd5;

   localparam logic [FREQ_W-1:0] MAJOR_FREQ_RESET = 17'd52429;
   localparam logic [FREQ_W-1:0] MINOR_FREQ_RESET = 17'd6554;

   typedef struct packed {
      logic [IN_CNT_W-1:0] count_a;
      logic [IN_CNT_W-1:0] count_c;
      logic [IN_CNT_W-1:0] count_g;
      logic [IN_CNT_W-1:0] count_t;
      logic [REF_W-1:0]    ref_base;
      logic                last_sample;
   } req_type;

   typedef struct packed {
      logic              site_kept;
      logic              major_variant;
      logic [BASE_W-1:0] alt_count;
      logic [BASE_W-1:0] alt_first;
      logic [BASE_W-1:0] alt_second;
      logic [BASE_W-1:0] alt_third;
      logic [SUM_W-1:0]  total_depth;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0]    major_freq_q16;
      logic [FREQ_W-1:0]    minor_freq_q16;
      logic [SUM_W-1:0]     min_population_depth;
      logic [SUM_W-1:0]     min_population_alt;
      logic [MIN_ALT_W-1:0] min_sample_alt;
      logic [MIN_DEP_W-1:0] min_sample_depth;
   } cfg_type;

   // One classified sample, handed from the front end to the accumulator.
   typedef struct packed {
      logic [BASES-1:0][IN_CNT_W-1:0] count;
      logic [IN_DEP_W-1:0]            depth;
      logic [BASES-1:0]               major_alt;
      logic [BASES-1:0]               minor_mark;
      logic [BASES-1:0]               major_mark;
      logic                           last;
   } item_type;

   // Per-position running state.
   typedef struct packed {
      logic [SUM_W-1:0]                  depth_sum;
      logic [BASES-1:0][SUM_W-1:0]       alt_sum;
      logic [ALT_SLOTS-1:0][BASE_W-1:0]  alt_list;
      logic [BASE_W-1:0]                 alt_len;
      logic                              variant;
      logic                              major;
   } site_type;

endpackage

[sv/snpsq_front.sv]
// Front end: masks the counts, forms the sample depth and runs the fraction tests.
module snpsq_front #(
   parameter int COUNT_BITS = snpsq_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  snpsq_pkg::req_type  req_data,
   input  snpsq_pkg::cfg_type  cfg,
   output logic                fe_valid,
   input  logic                fe_ready,
   output snpsq_pkg::item_type fe_item
);
   import snpsq_pkg::*;

   localparam int CNT_W = (COUNT_BITS < IN_CNT_W) ? COUNT_BITS : IN_CNT_W;
   localparam int DEP_W = CNT_W + 2;
   localparam int PRD_W = FREQ_W + DEP_W;

   logic [BASES-1:0][CNT_W-1:0] req_cnt;
   logic [DEP_W-1:0]            req_depth;

   logic                        s1_valid_ff, s1_valid_in;
   logic [BASES-1:0][CNT_W-1:0] s1_count_ff;
   logic [DEP_W-1:0]            s1_depth_ff;
   logic [REF_W-1:0]            s1_ref_ff;
   logic                        s1_last_ff;

   logic                        s2_valid_ff, s2_valid_in;
   logic [BASES-1:0][CNT_W-1:0] s2_count_ff;
   logic [DEP_W-1:0]            s2_depth_ff;
   logic [REF_W-1:0]            s2_ref_ff;
   logic                        s2_last_ff;
   logic [PRD_W-1:0]            s2_major_prod_ff, s2_major_prod_in;
   logic [PRD_W-1:0]            s2_minor_prod_ff, s2_minor_prod_in;
   logic                        s2_sample_ok_ff, s2_sample_ok_in;
   logic [BASES-1:0]            s2_cnt_ok_ff, s2_cnt_ok_in;

   logic                        s3_valid_ff, s3_valid_in;
   item_type                    s3_item_ff, s3_item_in;

   logic                        s1_adv, s2_adv, s3_adv;

   assign s3_adv    = !s3_valid_ff || fe_ready;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_stall = !s1_adv;

   assign s1_valid_in = s1_adv ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_adv ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      req_cnt[0] = req_data.count_a[CNT_W-1:0];
      req_cnt[1] = req_data.count_c[CNT_W-1:0];
      req_cnt[2] = req_data.count_g[CNT_W-1:0];
      req_cnt[3] = req_data.count_t[CNT_W-1:0];
      req_depth  = DEP_W'(req_cnt[0]) + DEP_W'(req_cnt[1])
                 + DEP_W'(req_cnt[2]) + DEP_W'(req_cnt[3]);
   end

   always_comb begin
      s2_major_prod_in = PRD_W'(cfg.major_freq_q16) * PRD_W'(s1_depth_ff);
      s2_minor_prod_in = PRD_W'(cfg.minor_freq_q16) * PRD_W'(s1_depth_ff);
      s2_sample_ok_in  = SUM_W'(s1_depth_ff) > SUM_W'(cfg.min_sample_depth);
      for (int b = 0; b < BASES; b++) begin
         s2_cnt_ok_in[b] = MIN_ALT_W'(s1_count_ff[b]) >= cfg.min_sample_alt;
      end
   end

   // Fraction test count/depth >= thr is done as count * 2^16 >= thr * depth.
   always_comb begin
      logic [PRD_W-1:0] lhs;
      logic             depth_nz;
      logic             alt;
      logic             major;
      logic             minor;
      logic             marks;
      lhs        = '0;
      alt        = 1'b0;
      major      = 1'b0;
      minor      = 1'b0;
      marks      = 1'b0;
      depth_nz   = s2_depth_ff != '0;
      s3_item_in = '0;
      for (int b = 0; b < BASES; b++) begin
         lhs   = PRD_W'(s2_count_ff[b]) << Q16_SHIFT;
         alt   = REF_W'(b) != s2_ref_ff;
         major = depth_nz && (lhs >= s2_major_prod_ff);
         minor = depth_nz && (lhs >= s2_minor_prod_ff);
         marks = alt && s2_sample_ok_ff && s2_cnt_ok_ff[b];
         s3_item_in.count[b]      = IN_CNT_W'(s2_count_ff[b]);
         s3_item_in.major_alt[b]  = major && alt;
         s3_item_in.minor_mark[b] = minor && marks;
         s3_item_in.major_mark[b] = major && marks;
      end
      s3_item_in.depth = IN_DEP_W'(s2_depth_ff);
      s3_item_in.last  = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_count_ff <= req_cnt;
         s1_depth_ff <= req_depth;
         s1_ref_ff   <= req_data.ref_base;
         s1_last_ff  <= req_data.last_sample;
      end
      if (s2_adv) begin
         s2_count_ff      <= s1_count_ff;
         s2_depth_ff      <= s1_depth_ff;
         s2_ref_ff        <= s1_ref_ff;
         s2_last_ff       <= s1_last_ff;
         s2_major_prod_ff <= s2_major_prod_in;
         s2_minor_prod_ff <= s2_minor_prod_in;
         s2_sample_ok_ff  <= s2_sample_ok_in;
         s2_cnt_ok_ff     <= s2_cnt_ok_in;
      end
      if (s3_adv) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign fe_valid = s3_valid_ff;
   assign fe_item  = s3_item_ff;

endmodule

[sv/snpsq_queue.sv]
// Short queue of classified samples between the front end and the accumulator.
module snpsq_queue #(
   parameter int DEPTH = snpsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  snpsq_pkg::item_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output snpsq_pkg::item_type pop_item
);
   import snpsq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   item_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]     level_ff, level_in;
   logic                 push, pop;

   assign push_ready = level_ff != LVL_W'(DEPTH);
   assign pop_valid  = level_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/snpsq_back.sv]
// Back end: accumulates per-position sums and alternates, then forms the site verdict.
module snpsq_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  snpsq_pkg::item_type q_item,
   input  snpsq_pkg::cfg_type  cfg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output snpsq_pkg::rsp_type  rsp_data
);
   import snpsq_pkg::*;

   site_type site_ff, site_in, site_upd;
   site_type fin_ff;
   logic     fin_valid_ff, fin_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   logic     out_ready, fin_ready, pop;

   function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fin_ready = !fin_valid_ff || out_ready;
   assign q_ready   = fin_ready;
   assign pop       = q_valid && fin_ready;

   // Alternates are appended in base order, so a base listed by an earlier
   // base of the same sample is seen by the later ones.
   always_comb begin
      logic found;
      found    = 1'b0;
      site_upd = site_ff;
      site_upd.depth_sum = sat_add(site_ff.depth_sum, SUM_W'(q_item.depth));
      for (int b = 0; b < BASES; b++) begin
         if (q_item.major_alt[b]) begin
            site_upd.alt_sum[b] = sat_add(site_ff.alt_sum[b], SUM_W'(q_item.count[b]));
         end
         if (q_item.major_mark[b]) begin
            site_upd.major = 1'b1;
         end
         if (q_item.minor_mark[b]) begin
            site_upd.variant = 1'b1;
            found = 1'b0;
            for (int k = 0; k < ALT_SLOTS; k++) begin
               if ((BASE_W'(k) < site_upd.alt_len) && (site_upd.alt_list[k] == BASE_W'(b))) begin
                  found = 1'b1;
               end
            end
            if (!found && (site_upd.alt_len < BASE_W'(ALT_SLOTS))) begin
               site_upd.alt_list[site_upd.alt_len] = BASE_W'(b);
               site_upd.alt_len = site_upd.alt_len + 1'b1;
            end
         end
      end
   end

   always_comb begin
      site_in      = site_ff;
      fin_valid_in = fin_valid_ff;
      if (out_ready) begin
         fin_valid_in = 1'b0;
      end
      if (pop) begin
         if (q_item.last) begin
            site_in      = '0;
            fin_valid_in = 1'b1;
         end else begin
            site_in = site_upd;
         end
      end
   end

   always_comb begin
      logic pop_alt;
      pop_alt = 1'b0;
      for (int b = 0; b < BASES; b++) begin
         if (fin_ff.alt_sum[b] > cfg.min_population_alt) begin
            pop_alt = 1'b1;
         end
      end
      rsp_data_in.site_kept     = (fin_ff.depth_sum >= cfg.min_population_depth)
                                  && pop_alt && fin_ff.variant;
      rsp_data_in.major_variant = fin_ff.major;
      rsp_data_in.alt_count     = fin_ff.alt_len;
      rsp_data_in.alt_first     = fin_ff.alt_list[0];
      rsp_data_in.alt_second    = fin_ff.alt_list[1];
      rsp_data_in.alt_third     = fin_ff.alt_list[2];
      rsp_data_in.total_depth   = fin_ff.depth_sum;
      rsp_valid_in = out_ready ? fin_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_ff      <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         site_ff      <= site_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && q_item.last) begin
         fin_ff <= site_upd;
      end
      if (out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/snp_site_qualifier.sv]
// Throughput: one sample item per cycle while the queue has room; a full queue stalls req_.
// A last-sample item passes through three front-end stages, one queue slot, a verdict
// stage and the output register before its result is valid; while rsp_stall holds,
// the result waits in the output register.
// The queue between front end and accumulator absorbs short output stalls.
// Reset is synchronous: registers return to their reset values and all per-position
// sums and alternate lists clear at once; no sweep is needed before items are taken.
module snp_site_qualifier #(
   parameter int COUNT_BITS  = snpsq_pkg::COUNT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = snpsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  snpsq_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output snpsq_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [snpsq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [snpsq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import snpsq_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     fe_valid, q_ready_push;
   item_type fe_item;
   logic     q_valid, q_ready;
   item_type q_item;

   assign csr_ready = 1'b1;

   // Writes to indexes outside the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAJOR_FREQ:       cfg_in.major_freq_q16       = FREQ_W'(csr_wdata);
            CSR_MINOR_FREQ:       cfg_in.minor_freq_q16       = FREQ_W'(csr_wdata);
            CSR_MIN_POP_DEPTH:    cfg_in.min_population_depth = SUM_W'(csr_wdata);
            CSR_MIN_POP_ALT:      cfg_in.min_population_alt   = SUM_W'(csr_wdata);
            CSR_MIN_SAMPLE_ALT:   cfg_in.min_sample_alt       = MIN_ALT_W'(csr_wdata);
            CSR_MIN_SAMPLE_DEPTH: cfg_in.min_sample_depth     = MIN_DEP_W'(csr_wdata);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.major_freq_q16       <= MAJOR_FREQ_RESET;
         cfg_ff.minor_freq_q16       <= MINOR_FREQ_RESET;
         cfg_ff.min_population_depth <= '0;
         cfg_ff.min_population_alt   <= '0;
         cfg_ff.min_sample_alt       <= '0;
         cfg_ff.min_sample_depth     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   snpsq_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .fe_valid  (fe_valid),
      .fe_ready  (q_ready_push),
      .fe_item   (fe_item)
   );

   snpsq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_ready (q_ready_push),
      .push_item  (fe_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   snpsq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A kept site always has at least one listed alternate.
   a_kept_has_alt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.site_kept |-> rsp_data.alt_count != 2'd0)
      else $error("site kept without a listed alternate");

   // With no reads at all, nothing can be marked.
   a_empty_site: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.total_depth == '0) |->
         !rsp_data.major_variant && (rsp_data.alt_count == 2'd0))
      else $error("marks reported on a site with zero depth");

   // Unused alternate slots read as zero.
   a_unused_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.alt_count == 2'd0) || (rsp_data.alt_count == 2'd1)) |->
         (rsp_data.alt_second == 2'd0) && (rsp_data.alt_third == 2'd0))
      else $error("alternate slot beyond count is nonzero");

   // A sample held back by a full queue is not dropped by the front end.
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      fe_valid && !q_ready_push |=> fe_valid)
      else $error("front end dropped a sample while the queue was full");

endmodule
